// ===== rtl/rle8d_pkg.sv =====
// Package for the RLE8 bitmap decoder: beat structs, config struct,
// decode phase encoding and register indexes. No dependencies.
`timescale 1ns / 1ps

package rle8d_pkg;

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 72;
   localparam int ADDR_W      = 28;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_PITCH    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_X     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_Y     = 2'd3;

   localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd1;

   typedef enum logic [2:0] {
      PH_CODE   = 3'd0,
      PH_SECOND = 3'd1,
      PH_DX     = 3'd2,
      PH_DY     = 3'd3,
      PH_ABS    = 3'd4,
      PH_PAD    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       starts_image;
   } req_beat_type;

   typedef struct packed {
      logic              image_done;
      logic [7:0]        palette_index;
      logic [7:0]        run_length;
      logic [ADDR_W-1:0] byte_address;
      logic [11:0]       pixel_column;
      logic [11:0]       pixel_row;
   } rsp_beat_type;

   typedef struct packed {
      logic [12:0] image_height;
      logic [13:0] row_pitch;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
   } cfg_type;

endpackage

// ===== rtl/rle8d_in_stage.sv =====
// Input register for the RLE8 decoder: holds one request beat until decode
// takes it. Depends on rle8d_pkg.
`timescale 1ns / 1ps

module rle8d_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rle8d_pkg::req_beat_type  in_beat,
   input  logic                     advance,
   output logic                     beat_valid,
   output rle8d_pkg::req_beat_type  beat
);

   logic                    valid_ff;
   logic                    valid_in;
   rle8d_pkg::req_beat_type beat_ff;

   assign in_ready   = !valid_ff || advance;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_comb begin
      valid_in = valid_ff && !advance;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

// ===== rtl/rle8d_decode.sv =====
// Decode state and single-pass RLE8 decode: phase, position and run state,
// write address computation. Depends on rle8d_pkg.
`timescale 1ns / 1ps

module rle8d_decode #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rle8d_pkg::cfg_type       cfg,
   input  logic                     advance,
   input  rle8d_pkg::req_beat_type  beat,
   output logic                     res_valid,
   output rle8d_pkg::rsp_beat_type  res
);

   localparam int ROW_W  = $clog2(MAX_DIMENSION);
   localparam int COL_W  = $clog2(MAX_DIMENSION + 1);
   localparam int CMP_W  = ((COL_W > 8) ? COL_W : 8) + 1;
   localparam int DY_W   = (ROW_W > 8) ? ROW_W : 8;
   localparam int HT_W   = 17;
   localparam int SUM_W  = ((ROW_W > 12) ? ROW_W : 12) + 1;
   localparam int PROD_W = 14 + SUM_W;
   localparam int ACC_W  = (PROD_W + 1 > rle8d_pkg::ADDR_W) ? PROD_W + 1 : rle8d_pkg::ADDR_W;

   rle8d_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           held_ff, held_in;
   logic [7:0]           abs_left_ff, abs_left_in;
   logic                 pad_ff, pad_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 fin_ff, fin_in;

   rle8d_pkg::phase_type ph;
   logic [ROW_W-1:0]     row;
   logic [COL_W-1:0]     col;
   logic                 fin;
   logic [HT_W-1:0]      height;
   logic [ROW_W-1:0]     top_row;
   logic                 put_req;
   logic [7:0]           put_len;
   logic [7:0]           put_idx;
   logic [CMP_W-1:0]     col_sum;
   logic [CMP_W-1:0]     dx_sum;
   logic [SUM_W-1:0]     dest_row;
   logic [ACC_W-1:0]     addr_full;
   logic [31:0]          row_ext;
   logic [31:0]          col_ext;

   always_comb begin
      height = HT_W'(cfg.image_height);
      if (height == '0) begin
         height = HT_W'(1);
      end
      if (height > HT_W'(MAX_DIMENSION)) begin
         height = HT_W'(MAX_DIMENSION);
      end
      top_row = ROW_W'(height - HT_W'(1));
   end

   always_comb begin
      ph          = phase_ff;
      row         = row_ff;
      col         = col_ff;
      fin         = fin_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      abs_left_in = abs_left_ff;
      pad_in      = pad_ff;
      if (beat.starts_image) begin
         ph          = rle8d_pkg::PH_CODE;
         row         = top_row;
         col         = '0;
         fin         = 1'b0;
         phase_in    = rle8d_pkg::PH_CODE;
         held_in     = '0;
         abs_left_in = '0;
         pad_in      = 1'b0;
      end
      row_in    = row;
      col_in    = col;
      fin_in    = fin;
      res_valid = 1'b0;
      res       = '0;
      put_req   = 1'b0;
      put_len   = 8'd1;
      put_idx   = beat.data_byte;
      dx_sum    = CMP_W'(col) + CMP_W'(beat.data_byte);

      if (!fin) begin
         unique case (ph)
            rle8d_pkg::PH_CODE: begin
               held_in  = beat.data_byte;
               phase_in = rle8d_pkg::PH_SECOND;
            end
            rle8d_pkg::PH_SECOND: begin
               phase_in = rle8d_pkg::PH_CODE;
               if (held_in != 8'd0) begin
                  put_req = 1'b1;
                  put_len = held_in;
               end else if (beat.data_byte == 8'd0) begin
                  if (row == '0) begin
                     res_valid      = 1'b1;
                     res.image_done = 1'b1;
                     fin_in         = 1'b1;
                  end else begin
                     row_in = row - ROW_W'(1);
                     col_in = '0;
                  end
               end else if (beat.data_byte == 8'd1) begin
                  res_valid      = 1'b1;
                  res.image_done = 1'b1;
                  fin_in         = 1'b1;
               end else if (beat.data_byte == 8'd2) begin
                  phase_in = rle8d_pkg::PH_DX;
               end else begin
                  abs_left_in = beat.data_byte;
                  pad_in      = beat.data_byte[0];
                  phase_in    = rle8d_pkg::PH_ABS;
               end
            end
            rle8d_pkg::PH_DX: begin
               if (dx_sum > CMP_W'(MAX_DIMENSION)) begin
                  col_in = COL_W'(MAX_DIMENSION);
               end else begin
                  col_in = COL_W'(dx_sum);
               end
               phase_in = rle8d_pkg::PH_DY;
            end
            rle8d_pkg::PH_DY: begin
               phase_in = rle8d_pkg::PH_CODE;
               if (DY_W'(beat.data_byte) > DY_W'(row)) begin
                  res_valid      = 1'b1;
                  res.image_done = 1'b1;
                  fin_in         = 1'b1;
               end else begin
                  row_in = ROW_W'(DY_W'(row) - DY_W'(beat.data_byte));
               end
            end
            rle8d_pkg::PH_ABS: begin
               if (abs_left_in != 8'd0) begin
                  abs_left_in = abs_left_in - 8'd1;
               end
               if (abs_left_in == 8'd0) begin
                  phase_in = pad_in ? rle8d_pkg::PH_PAD : rle8d_pkg::PH_CODE;
               end
               put_req = 1'b1;
            end
            rle8d_pkg::PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = rle8d_pkg::PH_CODE;
            end
            default: begin
               phase_in = rle8d_pkg::PH_CODE;
            end
         endcase
      end

      col_sum   = CMP_W'(col) + CMP_W'(put_len);
      dest_row  = SUM_W'(row) + SUM_W'(cfg.origin_y);
      addr_full = ACC_W'(cfg.row_pitch) * ACC_W'(dest_row)
                  + ACC_W'(cfg.origin_x) + ACC_W'(col);
      row_ext   = 32'(row);
      col_ext   = 32'(col);

      if (put_req) begin
         if (col_sum > CMP_W'(MAX_DIMENSION)) begin
            col_in = COL_W'(MAX_DIMENSION);
         end else begin
            res_valid         = 1'b1;
            res.pixel_row     = row_ext[11:0];
            res.pixel_column  = col_ext[11:0];
            res.byte_address  = addr_full[rle8d_pkg::ADDR_W-1:0];
            res.run_length    = put_len;
            res.palette_index = put_idx;
            col_in            = COL_W'(col_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rle8d_pkg::PH_CODE;
         held_ff     <= '0;
         abs_left_ff <= '0;
         pad_ff      <= 1'b0;
         row_ff      <= '0;
         col_ff      <= '0;
         fin_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         abs_left_ff <= abs_left_in;
         pad_ff      <= pad_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         fin_ff      <= fin_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && res.image_done |=> fin_ff)
      else $error("end of image did not stop decoding");

   a_finished_is_silent: assert property (@(posedge clock) disable iff (reset)
      advance && fin_ff && !beat.starts_image |-> !res_valid)
      else $error("result after end of image");

   a_column_bounded: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(MAX_DIMENSION))
      else $error("column past saturation");

   a_write_has_length: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.image_done |-> res.run_length != 8'd0)
      else $error("pixel write with zero length");
`endif

endmodule

// ===== rtl/rle8d_out_stage.sv =====
// Result register for the RLE8 decoder: holds one response beat until the
// receiver takes it. Depends on rle8d_pkg.
`timescale 1ns / 1ps

module rle8d_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     load_valid,
   input  rle8d_pkg::rsp_beat_type  load_beat,
   output logic                     ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rle8d_pkg::rsp_beat_type  out_beat
);

   logic                    valid_ff;
   logic                    valid_in;
   rle8d_pkg::rsp_beat_type beat_ff;

   assign ready     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      if (load) begin
         valid_in = load_valid;
      end else begin
         valid_in = valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         beat_ff <= load_beat;
      end
   end

endmodule

// ===== rtl/bmp_rle8_decoder_core.sv =====
// RLE8 bitmap stream decoder: configuration registers, input register, decode
// and result register. Depends on rle8d_pkg, rle8d_in_stage, rle8d_decode,
// rle8d_out_stage.
//
// Usage: compressed bytes of a bottom-up 8-bit bitmap enter on req_ (one per
// beat); req_tuser marks the first byte of an image. Each byte yields zero
// or one pixel-write beat on rsp_: row, column, destination byte address,
// run length and palette index; rsp_tlast marks the end-of-image beat,
// whose other fields are zero. Write csr_ registers only while idle.
// An accepted byte waits in the input register and decodes into the result
// register. Throughput: one byte per cycle while the result register can load
// (empty or rsp_tready high), set by the single decode stage.
// Reset: both registers empty, decoding at row 0 column 0 of a one-row image;
// configuration returns to height 1, pitch and origins 0.
// Stall: while rsp_tready is low the result holds, decode stops, and at most one
// further byte is taken into the input register before req_tready drops.
`timescale 1ns / 1ps

module bmp_rle8_decoder_core #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [rle8d_pkg::REQ_TDATA_W-1:0]      req_tdata,  // data_byte[7:0]
   input  logic [0:0]                             req_tuser,  // starts_image[0]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pixel_row[11:0], pixel_column[23:12], byte_address[51:24],
   // run_length[59:52], palette_index[67:60], zero[71:68]
   output logic [rle8d_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,  // image_done
   input  logic                                   csr_we,
   input  logic [rle8d_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [rle8d_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   rle8d_pkg::cfg_type       cfg_ff, cfg_in;
   rle8d_pkg::req_beat_type  in_beat;
   rle8d_pkg::req_beat_type  beat;
   rle8d_pkg::rsp_beat_type  res;
   rle8d_pkg::rsp_beat_type  out_beat;
   logic                     beat_valid;
   logic                     out_free;
   logic                     advance;
   logic                     res_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            rle8d_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[12:0];
            rle8d_pkg::CSR_ROW_PITCH:    cfg_in.row_pitch    = csr_wdata[13:0];
            rle8d_pkg::CSR_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[11:0];
            rle8d_pkg::CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[11:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height <= rle8d_pkg::IMAGE_HEIGHT_RESET;
         cfg_ff.row_pitch    <= '0;
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign in_beat.data_byte    = req_tdata[7:0];
   assign in_beat.starts_image = req_tuser[0];
   assign advance              = beat_valid && out_free;

   rle8d_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_beat    (in_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   rle8d_decode #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .advance   (advance),
      .beat      (beat),
      .res_valid (res_valid),
      .res       (res)
   );

   rle8d_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (res_valid),
      .load_beat  (res),
      .ready      (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (out_beat)
   );

   assign rsp_tdata = {4'b0000, out_beat.palette_index, out_beat.run_length,
                       out_beat.byte_address, out_beat.pixel_column, out_beat.pixel_row};
   assign rsp_tlast = out_beat.image_done;

endmodule
